[hdl/rgbac_pkg.sv]
package rgbac_pkg;

    // factor select codes
    localparam logic [1:0] MODE_ALPHA     = 2'd0;
    localparam logic [1:0] MODE_INV_ALPHA = 2'd1;
    localparam logic [1:0] MODE_ONE       = 2'd2;
    localparam logic [1:0] MODE_ZERO      = 2'd3;

    // register indexes
    localparam logic REG_FACTOR_A = 1'b0;
    localparam logic REG_FACTOR_B = 1'b1;

    localparam logic [1:0] FACTOR_A_RESET = MODE_ONE;
    localparam logic [1:0] FACTOR_B_RESET = MODE_INV_ALPHA;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

endpackage

[hdl/rgbac_weight.sv]
module rgbac_weight #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [1:0]   i_mode_a,
    input  logic [1:0]   i_mode_b,
    input  logic [W-1:0] i_alpha_a,
    input  logic [W-1:0] i_alpha_b,
    output logic [W-1:0] o_weight_a,
    output logic [W-1:0] o_weight_b
);

    localparam logic [W-1:0]   ONE  = {W{1'b1}};
    localparam logic [2*W-1:0] HALF = (2*W)'(ONE >> 1);

    function automatic logic [W-1:0] pick(input logic [1:0] mode, input logic [W-1:0] alpha);
        logic [W-1:0] f;
        unique case (mode)
            rgbac_pkg::MODE_ALPHA:     f = alpha;
            rgbac_pkg::MODE_INV_ALPHA: f = ONE - alpha;
            rgbac_pkg::MODE_ONE:       f = ONE;
            rgbac_pkg::MODE_ZERO:      f = '0;
            default:                   f = '0;
        endcase
        return f;
    endfunction

    // x * y / ONE rounded: split p at W bits, fold the high half back, one correction
    function automatic logic [W-1:0] div_one(input logic [2*W-1:0] p);
        logic [W-1:0] q0;
        logic [W:0]   t;
        q0 = p[2*W-1:W];
        t  = {1'b0, p[W-1:0]} + {1'b0, q0};
        return q0 + ((t >= {1'b0, ONE}) ? W'(1) : W'(0));
    endfunction

    logic [2*W-1:0] r_prod_a, r_prod_b;
    logic [W-1:0]   r_weight_a, r_weight_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_a   <= i_alpha_a * pick(i_mode_a, i_alpha_b) + HALF;
            r_prod_b   <= i_alpha_b * pick(i_mode_b, i_alpha_a) + HALF;
            r_weight_a <= div_one(r_prod_a);
            r_weight_b <= div_one(r_prod_b);
        end
    end

    assign o_weight_a = r_weight_a;
    assign o_weight_b = r_weight_b;

endmodule

[hdl/rgbac_blend.sv]
module rgbac_blend #(
    parameter int W = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [W-1:0]    i_col_a [3],
    input  logic [W-1:0]    i_col_b [3],
    input  logic [W-1:0]    i_weight_a,
    input  logic [W-1:0]    i_weight_b,
    output logic [2*W+1:0]  o_dividend [3],
    output logic [W:0]      o_sum
);

    localparam int DW = 2 * W + 2;

    logic [2*W-1:0] r_ma [3];
    logic [2*W-1:0] r_mb [3];
    logic [W:0]     r_sum, r_sum_d;
    logic [DW-1:0]  r_div [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_ma[k]  <= i_col_a[k] * i_weight_a;
                r_mb[k]  <= i_col_b[k] * i_weight_b;
                // add half the divisor so the divide rounds to nearest
                r_div[k] <= DW'(r_ma[k]) + DW'(r_mb[k]) + DW'(r_sum >> 1);
            end
            r_sum   <= {1'b0, i_weight_a} + {1'b0, i_weight_b};
            r_sum_d <= r_sum;
        end
    end

    assign o_dividend = r_div;
    assign o_sum      = r_sum_d;

endmodule

[hdl/rgbac_div.sv]
module rgbac_div #(
    parameter int W = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W+1:0] i_dividend,
    input  logic [W:0]     i_divisor,
    output logic [W-1:0]   o_quotient,
    output logic [W:0]     o_divisor
);

    localparam int DW = 2 * W + 2;

    logic [DW-1:0] r_rem [W];
    logic [W-1:0]  r_q   [W];
    logic [W:0]    r_d   [W];

    // one quotient bit per stage, most significant first
    for (genvar i = 0; i < W; i++) begin : g_stage
        localparam int K = W - 1 - i;
        logic [DW-1:0] rem_in, shifted;
        logic [W-1:0]  q_in, n_q;
        logic [W:0]    d_in;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = i_dividend;
            assign q_in   = '0;
            assign d_in   = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign q_in   = r_q[i-1];
            assign d_in   = r_d[i-1];
        end

        always_comb begin
            shifted = DW'(d_in) << K;
            ge      = rem_in >= shifted;
            n_q     = q_in;
            n_q[K]  = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i] <= ge ? rem_in - shifted : rem_in;
                r_q[i]   <= n_q;
                r_d[i]   <= d_in;
            end
        end
    end

    assign o_quotient = r_q[W-1];
    assign o_divisor  = r_d[W-1];

endmodule

[hdl/rgba_alpha_compositor_top.sv]
// Pipeline from input transfer to output: the alpha weight stages, the colour
//   product and rounding offset stages, a restoring divider stage for each quotient
//   bit, then the output register.
// Throughput: one pixel per cycle while the output side takes transfers.
// Reset (synchronous, active low) clears all valid bits and selects "over".
module rgba_alpha_compositor_top #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // slave side: a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [8*CHANNEL_BITS-1:0]   s_tdata,
    // master side: out_red, out_green, out_blue, out_alpha, zero padded to bytes
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((4*CHANNEL_BITS+7)/8)*8-1:0] m_tdata,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rgbac_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [rgbac_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [rgbac_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                        pready
);

    localparam int W     = CHANNEL_BITS;
    localparam int DW    = 2 * W + 2;
    localparam int LAT   = W + 5;
    localparam int OUT_W = ((4 * W + 7) / 8) * 8;
    localparam logic [W-1:0] ONE = {W{1'b1}};

    // ---------------- register port ----------------
    logic [1:0] r_mode_a, r_mode_b;
    logic       reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_a <= rgbac_pkg::FACTOR_A_RESET;
            r_mode_b <= rgbac_pkg::FACTOR_B_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                rgbac_pkg::REG_FACTOR_A: r_mode_a <= pwdata[1:0];
                rgbac_pkg::REG_FACTOR_B: r_mode_b <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rgbac_pkg::REG_FACTOR_A: prdata = {30'd0, r_mode_a};
            rgbac_pkg::REG_FACTOR_B: prdata = {30'd0, r_mode_b};
            default:                 prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // The whole pipe advances together; hold everything only when the output
    // register is full and the downstream side refuses the transfer.
    logic           adv;
    logic [LAT-1:0] r_vld;

    assign adv      = !r_vld[LAT-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- input unpacking ----------------
    logic [W-1:0] in_col_a [3];
    logic [W-1:0] in_col_b [3];
    logic [W-1:0] in_alpha_a, in_alpha_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_col_a[k] = s_tdata[k*W +: W];
            in_col_b[k] = s_tdata[(4+k)*W +: W];
        end
    end
    assign in_alpha_a = s_tdata[3*W +: W];
    assign in_alpha_b = s_tdata[7*W +: W];

    // ---------------- alpha weights (two stages) ----------------
    logic [W-1:0] weight_a, weight_b;

    rgbac_weight #(.W(W)) u_weight (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_mode_a   (r_mode_a),
        .i_mode_b   (r_mode_b),
        .i_alpha_a  (in_alpha_a),
        .i_alpha_b  (in_alpha_b),
        .o_weight_a (weight_a),
        .o_weight_b (weight_b)
    );

    // delay the colours to line up with the weights
    logic [W-1:0] r_ca1 [3];
    logic [W-1:0] r_cb1 [3];
    logic [W-1:0] r_ca2 [3];
    logic [W-1:0] r_cb2 [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ca1 <= in_col_a;
            r_cb1 <= in_col_b;
            r_ca2 <= r_ca1;
            r_cb2 <= r_cb1;
        end
    end

    // ---------------- colour products and rounding (two stages) ----------------
    logic [DW-1:0] dividend [3];
    logic [W:0]    alpha_sum;

    rgbac_blend #(.W(W)) u_blend (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_col_a    (r_ca2),
        .i_col_b    (r_cb2),
        .i_weight_a (weight_a),
        .i_weight_b (weight_b),
        .o_dividend (dividend),
        .o_sum      (alpha_sum)
    );

    // ---------------- restoring dividers, one per colour ----------------
    logic [W-1:0] quot [3];
    logic [W:0]   div_sum [3];

    for (genvar k = 0; k < 3; k++) begin : g_div
        rgbac_div #(.W(W)) u_div (
            .i_clk      (i_clk),
            .i_en       (adv),
            .i_dividend (dividend[k]),
            .i_divisor  (alpha_sum),
            .o_quotient (quot[k]),
            .o_divisor  (div_sum[k])
        );
    end

    // ---------------- output register ----------------
    // Zero alpha sum drops the colours to zero; alpha saturates at one.
    // The quotient is a weighted average of colours and never exceeds one.
    logic [W-1:0] r_out_col [3];
    logic [W-1:0] r_out_alpha;
    logic         sum_zero;

    assign sum_zero = (div_sum[0] == '0);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_out_col[k] <= sum_zero ? '0 : quot[k];
            end
            r_out_alpha <= (div_sum[0] > {1'b0, ONE}) ? ONE : div_sum[0][W-1:0];
        end
    end

    assign m_tvalid = r_vld[LAT-1];
    assign m_tdata  = OUT_W'({r_out_alpha, r_out_col[2], r_out_col[1], r_out_col[0]});

    // ---------------- checks ----------------
    a_zero_alpha_zero_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out_alpha == '0) |->
        (r_out_col[0] == '0 && r_out_col[1] == '0 && r_out_col[2] == '0))
        else $error("colour non-zero with zero alpha");

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    a_reset_empties_pipe: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output valid after reset");

    a_stall_holds_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> (r_vld == $past(r_vld)))
        else $error("pipeline moved while stalled");

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CB = 16;
    localparam logic [31:0] UNIT = 32'd65535;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_pixel;

    // Expected pixels in order, with its own copy of the factor modes.
    class t_composite_board;
        logic [1:0] mode_a;
        logic [1:0] mode_b;
        t_pixel     pending[$];
        int         errors;
        int         checked;

        function new();
            mode_a = rgbac_pkg::FACTOR_A_RESET;
            mode_b = rgbac_pkg::FACTOR_B_RESET;
            errors = 0;
            checked = 0;
        endfunction

        function logic [31:0] factor(logic [1:0] m, logic [15:0] a);
            case (m)
                rgbac_pkg::MODE_ALPHA:     return {16'd0, a};
                rgbac_pkg::MODE_INV_ALPHA: return UNIT - {16'd0, a};
                rgbac_pkg::MODE_ONE:       return UNIT;
                default:                   return 32'd0;
            endcase
        endfunction

        function logic [31:0] scale(logic [31:0] x, logic [31:0] y);
            logic [63:0] p;
            p = x * y + (UNIT >> 1);
            return 32'(p / UNIT);
        endfunction

        function void note_pair(logic [127:0] d);
            t_pixel pa, pb, r;
            logic [31:0] wa, wb, total;
            logic [63:0] num, q;
            pa = d[63:0];
            pb = d[127:64];
            wa = scale(32'(pa.alpha), factor(mode_a, pb.alpha));
            wb = scale(32'(pb.alpha), factor(mode_b, pa.alpha));
            total = wa + wb;
            r.alpha = (total > UNIT) ? 16'hFFFF : total[15:0];
            for (int k = 0; k < 3; k++) begin
                q = 0;
                if (total != 0) begin
                    num = pa[k*16 +: 16] * wa + pb[k*16 +: 16] * wb;
                    q = (num + (total >> 1)) / total;
                    if (q > UNIT) q = UNIT;
                end
                r[k*16 +: 16] = q[15:0];
            end
            pending = {pending, r};
        endfunction

        function void check_pixel(logic [63:0] d);
            t_pixel got, want;
            got = d;
            if (pending.size() == 0) begin
                $error("unexpected output pixel %h", d);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.red !== want.red) begin
                $error("out_red expected %h actual %h", want.red, got.red); errors++;
            end
            if (got.green !== want.green) begin
                $error("out_green expected %h actual %h", want.green, got.green); errors++;
            end
            if (got.blue !== want.blue) begin
                $error("out_blue expected %h actual %h", want.blue, got.blue); errors++;
            end
            if (got.alpha !== want.alpha) begin
                $error("out_alpha expected %h actual %h", want.alpha, got.alpha); errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // a_red, a_green, a_blue, a_alpha, b_red, b_green, b_blue, b_alpha
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic         psel, penable, pwrite;
    logic [rgbac_pkg::APB_ADDR_BITS-1:0] paddr;
    logic [rgbac_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [rgbac_pkg::APB_DATA_BITS-1:0] prdata;
    logic         pready;

    rgba_alpha_compositor_top #(.CHANNEL_BITS(CB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    t_composite_board board;
    int  send_idle_pct;   // chance in a hundred that the sender idles
    int  recv_stall_pct;  // chance in a hundred that the receiver stalls
    int  quiet_cycles;
    int  sent_total;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: decide stalls at the falling edge, take transfers at the rising edge.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) board.check_pixel(m_tdata);
    end

    // Watchdog: count cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAIL rgba_alpha_compositor_top");
                $finish;
            end
        end
    end

    // Write one register over the APB port: setup cycle then access cycle.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == rgbac_pkg::REG_FACTOR_A) board.mode_a = value[1:0];
        else board.mode_b = value[1:0];
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Offer one pixel pair; hold it until the transfer, idle at random first.
    task automatic send_pair(input logic [127:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge i_clk); while (!s_tready);
        board.note_pair(d);
        sent_total++;
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    // Wait until every expected pixel has arrived, then let the pipeline empty.
    task automatic drain();
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            3: return 16'hFFFF - 16'($urandom_range(255));
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [127:0] rand_pair();
        logic [127:0] d;
        for (int k = 0; k < 8; k++) d[k*16 +: 16] = rand_channel();
        return d;
    endfunction

    initial begin
        logic [127:0] d;
        logic [1:0] ma, mb;
        board = new();
        send_idle_pct = 0; recv_stall_pct = 0; sent_total = 0;
        i_rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset setting ("over"): extremes and zero alpha.
        send_pair('0);
        send_pair('1);
        send_pair({64'h0000_FFFF_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF});
        send_pair({64'hFFFF_1234_5678_9ABC, 64'h8000_0001_FFFF_0000});
        send_pair({64'h8000_AAAA_5555_FFFF, 64'h7FFF_5555_AAAA_0000});
        end_burst();
        drain();
        // Every mode pair once; one/one pushes the alpha sum above one.
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                write_reg(rgbac_pkg::REG_FACTOR_A, 32'(a) | 32'hFFFF_FFF0);
                write_reg(rgbac_pkg::REG_FACTOR_B, 32'(b));
                send_pair({64'hFFFF_FFFF_0000_8000, 64'hFFFF_0000_FFFF_4000});
                end_burst();
                drain();
            end
        end
        write_reg(rgbac_pkg::REG_FACTOR_A, 32'(rgbac_pkg::MODE_ONE));
        write_reg(rgbac_pkg::REG_FACTOR_B, 32'(rgbac_pkg::MODE_ONE));
        send_pair({64'hC000_FFFF_0000_FFFF, 64'hC000_0000_FFFF_0000});
        send_pair({64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF});
        end_burst();
        drain();

        // Random part: idling phases, each with a few mode settings.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int setting = 0; setting < 4; setting++) begin
                ma = 2'($urandom_range(3));
                mb = 2'($urandom_range(3));
                write_reg(rgbac_pkg::REG_FACTOR_A, 32'({$urandom(), ma}));
                write_reg(rgbac_pkg::REG_FACTOR_B, 32'(mb));
                for (int n = 0; n < 110; n++) begin
                    d = rand_pair();
                    // Stretches with no sender gaps between idle spells.
                    send_pair(d);
                end
                end_burst();
                drain();
            end
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();

        $display("covered %0d pixel pairs and %0d checked pixels over all mode pairs",
                 sent_total, board.checked);
        $display("idling phases: none, sender gaps, receiver stalls, both");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS rgba_alpha_compositor_top");
        end else begin
            $display("FAIL rgba_alpha_compositor_top");
        end
        $finish;
    end

endmodule
